// File: design/esw_pkg.sv
// Shared types, constants and item layout tables for the EEPROM shadow write-back unit.
package esw_pkg;

  localparam int IDX_W       = 4;
  localparam int BYTES_W     = 40;
  localparam int NUM_LANES   = BYTES_W / 8;
  localparam int ADDR_W      = 8;
  localparam int LEN_W       = 3;
  localparam int CSUM_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int TABLE_SLOTS = 16;

  localparam int DEF_NUM_ITEMS  = 11;
  localparam int MAX_ITEM_BYTES = 5;

  localparam logic [ADDR_W-1:0] DATA_BASE_RST = 8'h00;
  localparam logic [ADDR_W-1:0] CSUM_BASE_RST = 8'hF0;
  localparam logic [CSUM_W-1:0] CSUM_SEED     = 8'hFF;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_INIT  = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_BASE = 1'b0,
    CFG_CSUM_BASE = 1'b1
  } cfg_reg_t;

  localparam logic [3:0] ITEM_LEN [TABLE_SLOTS] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd2, 4'd1, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  localparam logic [ADDR_W-1:0] ITEM_OFF [TABLE_SLOTS] = '{
    8'd0, 8'd4, 8'd8, 8'd12, 8'd16, 8'd20, 8'd24, 8'd28,
    8'd32, 8'd34, 8'd35, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [BYTES_W-1:0] ITEM_DEFAULT [TABLE_SLOTS] = '{
    40'h0004310541, 40'h0005120632, 40'h0004330763, 40'h0006340894,
    40'h0003350955, 40'h0004360A76, 40'h0009370B37, 40'h0008380C08,
    40'h000000ABCD, 40'h0000000086, 40'h1E1D1C1B1A, 40'h0000000000,
    40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0000000000
  };

  typedef struct packed {
    logic [BYTES_W-1:0] read_bytes;
    logic               changed;
    logic               loaded_default;
    logic               write_valid;
    logic [ADDR_W-1:0]  write_address;
    logic [BYTES_W-1:0] write_bytes;
    logic [LEN_W-1:0]   write_length;
    logic [ADDR_W-1:0]  checksum_address;
    logic [CSUM_W-1:0]  checksum_value;
  } result_t;

  typedef struct packed {
    logic               shadow_we;
    logic [BYTES_W-1:0] shadow_val;
    logic               dirty_set;
    logic               dirty_clr;
    logic               scan_we;
    logic [IDX_W-1:0]   scan_val;
  } update_t;

  function automatic logic [3:0] item_len(input logic [IDX_W-1:0] idx);
    logic [3:0] n;
    n = ITEM_LEN[idx];
    if (n > 4'(MAX_ITEM_BYTES)) begin
      n = 4'(MAX_ITEM_BYTES);
    end
    return n;
  endfunction

  function automatic logic [BYTES_W-1:0] len_mask(input logic [3:0] n);
    logic [BYTES_W-1:0] m;
    m = '0;
    for (int b = 0; b < NUM_LANES; b++) begin
      if (4'(b) < n) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  function automatic logic [CSUM_W-1:0] check_sum(input logic [BYTES_W-1:0] bytes);
    logic [CSUM_W-1:0] sum;
    sum = '0;
    for (int b = 0; b < NUM_LANES; b++) begin
      sum = sum + bytes[8*b +: 8];
    end
    return CSUM_SEED - sum;
  endfunction

endpackage

// File: design/esw_item_logic.sv
// Combinational handling of one beat: request, init load or scan tick against one shadow entry.
module esw_item_logic (
  input  esw_pkg::action_t                  act,
  input  logic [esw_pkg::IDX_W-1:0]         entry_idx,
  input  logic                              entry_ok,
  input  logic [esw_pkg::BYTES_W-1:0]       item_bytes,
  input  logic [esw_pkg::CSUM_W-1:0]        stored_checksum,
  input  logic [esw_pkg::BYTES_W-1:0]       shadow_rd,
  input  logic                              dirty_rd,
  input  logic [esw_pkg::ADDR_W-1:0]        data_base,
  input  logic [esw_pkg::ADDR_W-1:0]        csum_base,
  output esw_pkg::result_t                  res,
  output esw_pkg::update_t                  upd
);
  import esw_pkg::*;

  logic [3:0]         len;
  logic [BYTES_W-1:0] mask;
  logic [BYTES_W-1:0] new_bytes;
  logic [BYTES_W-1:0] cur_bytes;

  assign len       = item_len(entry_idx);
  assign mask      = len_mask(len);
  assign new_bytes = item_bytes & mask;
  assign cur_bytes = shadow_rd & mask;

  always_comb begin
    res = '0;
    upd = '0;
    upd.shadow_val = new_bytes;
    unique case (act)
      ACT_TICK: begin
        upd.scan_we = 1'b1;
        if (entry_ok) begin
          upd.scan_val = entry_idx + IDX_W'(1);
          if (dirty_rd) begin
            res.write_valid      = 1'b1;
            res.write_address    = data_base + ITEM_OFF[entry_idx];
            res.write_bytes      = cur_bytes;
            res.write_length     = len[LEN_W-1:0];
            res.checksum_address = csum_base + ADDR_W'(entry_idx);
            res.checksum_value   = check_sum(cur_bytes);
            upd.dirty_clr        = 1'b1;
          end
        end else begin
          upd.scan_val = '0;
        end
      end
      ACT_WRITE: begin
        if (entry_ok && (new_bytes != cur_bytes)) begin
          upd.shadow_we = 1'b1;
          upd.dirty_set = 1'b1;
          res.changed   = 1'b1;
        end
      end
      ACT_READ: begin
        if (entry_ok) begin
          res.read_bytes = cur_bytes;
        end
      end
      ACT_INIT: begin
        if (entry_ok) begin
          upd.shadow_we = 1'b1;
          if (check_sum(new_bytes) != stored_checksum) begin
            upd.shadow_val     = ITEM_DEFAULT[entry_idx] & mask;
            upd.dirty_set      = (len != 4'd0);
            res.loaded_default = 1'b1;
          end
        end
      end
    endcase
  end

endmodule

// File: design/eeprom_shadow_writeback_unit.sv
// Top level of the EEPROM shadow write-back unit: beat registers, shadow store, dirty marks, scan.
// A beat is taken into the compute-stage register, then its result into the output register.
// Throughput: one beat per cycle; the compute stage advances whenever the output register is
// empty or its beat is taken in the same cycle, so the shadow update loop sets the rate.
// Reset (synchronous, active low): shadow bytes zero, dirty marks clear, scan position zero,
// data base address 0, checksum base address 240, and both beat registers empty.
module eeprom_shadow_writeback_unit #(
  parameter int NUM_ITEMS = esw_pkg::DEF_NUM_ITEMS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [esw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [esw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic [esw_pkg::IDX_W-1:0]         in_item_index,
  input  logic [esw_pkg::BYTES_W-1:0]       in_item_bytes,
  input  logic [esw_pkg::CSUM_W-1:0]        in_stored_checksum,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [esw_pkg::BYTES_W-1:0]       out_read_bytes,
  output logic                              out_changed,
  output logic                              out_loaded_default,
  output logic                              out_write_valid,
  output logic [esw_pkg::ADDR_W-1:0]        out_write_address,
  output logic [esw_pkg::BYTES_W-1:0]       out_write_bytes,
  output logic [esw_pkg::LEN_W-1:0]         out_write_length,
  output logic [esw_pkg::ADDR_W-1:0]        out_checksum_address,
  output logic [esw_pkg::CSUM_W-1:0]        out_checksum_value
);
  import esw_pkg::*;

  localparam int SEL_W = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;

  logic [ADDR_W-1:0]  data_base_r;
  logic [ADDR_W-1:0]  csum_base_r;

  logic               s1_valid_r;
  action_t            s1_act_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic [BYTES_W-1:0] s1_bytes_r;
  logic [CSUM_W-1:0]  s1_csum_r;

  logic               out_valid_r;
  result_t            out_r;

  logic [BYTES_W-1:0] shadow_r [NUM_ITEMS];
  logic [NUM_ITEMS-1:0] dirty_r;
  logic [IDX_W-1:0]   scan_pos_r;

  logic               advance;
  logic               proc;
  logic               in_fire;
  logic [IDX_W-1:0]   sel;
  logic               sel_ok;
  logic [SEL_W-1:0]   sel_i;
  logic [BYTES_W-1:0] shadow_rd;
  logic               dirty_rd;
  result_t            res;
  update_t            upd;

  assign advance  = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  assign sel       = (s1_act_r == ACT_TICK) ? scan_pos_r : s1_idx_r;
  assign sel_ok    = ({1'b0, sel} < (IDX_W+1)'(NUM_ITEMS));
  assign sel_i     = sel[SEL_W-1:0];
  assign shadow_rd = sel_ok ? shadow_r[sel_i] : '0;
  assign dirty_rd  = sel_ok ? dirty_r[sel_i] : 1'b0;

  esw_item_logic u_logic (
    .act             (s1_act_r),
    .entry_idx       (sel),
    .entry_ok        (sel_ok),
    .item_bytes      (s1_bytes_r),
    .stored_checksum (s1_csum_r),
    .shadow_rd       (shadow_rd),
    .dirty_rd        (dirty_rd),
    .data_base       (data_base_r),
    .csum_base       (csum_base_r),
    .res             (res),
    .upd             (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_base_r <= DATA_BASE_RST;
      csum_base_r <= CSUM_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DATA_BASE: data_base_r <= cfg_data;
        CFG_CSUM_BASE: csum_base_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_act_r   <= action_t'(in_action);
      s1_idx_r   <= in_item_index;
      s1_bytes_r <= in_item_bytes;
      s1_csum_r  <= in_stored_checksum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ITEMS; i++) begin
        shadow_r[i] <= '0;
      end
      dirty_r    <= '0;
      scan_pos_r <= '0;
    end else if (proc) begin
      if (upd.shadow_we) begin
        shadow_r[sel_i] <= upd.shadow_val;
      end
      if (upd.dirty_set) begin
        dirty_r[sel_i] <= 1'b1;
      end else if (upd.dirty_clr) begin
        dirty_r[sel_i] <= 1'b0;
      end
      if (upd.scan_we) begin
        scan_pos_r <= upd.scan_val;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_read_bytes       = out_r.read_bytes;
  assign out_changed          = out_r.changed;
  assign out_loaded_default   = out_r.loaded_default;
  assign out_write_valid      = out_r.write_valid;
  assign out_write_address    = out_r.write_address;
  assign out_write_bytes      = out_r.write_bytes;
  assign out_write_length     = out_r.write_length;
  assign out_checksum_address = out_r.checksum_address;
  assign out_checksum_value   = out_r.checksum_value;

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("Input stalled with an empty compute stage.");

  a_proc_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> out_valid_r)
    else $error("Processed beat did not reach the output register.");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones({out_r.changed, out_r.loaded_default, out_r.write_valid}) <= 1))
    else $error("More than one result flag is set.");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, scan_pos_r} <= (IDX_W+1)'(NUM_ITEMS))
    else $error("Scan position ran past the wrap point.");

endmodule
